// File: src/mct_pkg.sv
// ----------------------------------------------------------------------------
// Multiset count table package
// Shared types, codes and default sizes for the multiset count table unit.
// ----------------------------------------------------------------------------
package mct_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned KeyWidthDef   = 16;
  localparam int unsigned CountWidthDef = 32;

  // Operation codes carried in the op field
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // Input transaction
  typedef struct packed {
    logic        op;
    logic [15:0] key;
    logic [15:0] count;
  } mct_req_t;

  // Result transaction
  typedef struct packed {
    logic [31:0] key_count;
    logic        present;
    logic [4:0]  distinct_keys;
    logic [31:0] total_count;
    logic [15:0] least_key;
    logic [15:0] greatest_key;
    logic        empty_res;
    logic        full_error;
  } mct_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_UPD1,
    ST_UPD2
  } mct_state_e;

  // Table update chosen after the scan
  typedef enum logic [2:0] {
    ACT_QUERY,
    ACT_ADD_HIT,
    ACT_NEW,
    ACT_SUB_HIT,
    ACT_FULL
  } mct_act_e;

endpackage

// File: src/multiset_count_table_unit.sv
// ----------------------------------------------------------------------------
// Multiset count table unit
// Bounded bag of keys with per-key counts, kept in an unordered table.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The unit then
// walks the table memory one entry per cycle through a single key comparator,
// finding the matching entry, the first free entry and the least and greatest
// of the other keys in the same pass. The ST_UPD1 and ST_UPD2 states follow:
// the first works out the entry's new count, the second the new total, writes
// the table and registers the result. Busy stays high from the accepting edge
// until the result is registered; the result is shown on res_o for exactly
// one cycle with result_valid_o high, and busy is already low in that cycle,
// so a new transaction can be taken at its end. The unit cannot take a new
// transaction before it is through with the last one, since each one scans the
// whole table memory first. The receiver cannot hold
// a result off: sample it in its strobe cycle. Counts and the running total
// saturate at all ones of COUNT_WIDTH; table contents need no clearing after
// reset, only the per-entry valid flags are cleared.
// ----------------------------------------------------------------------------
module multiset_count_table_unit
  import mct_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned KEY_WIDTH   = KeyWidthDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  mct_req_t req_i,
  output logic     busy,
  output logic     result_valid_o,
  output mct_res_t res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned DW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = KEY_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;

  // Sequencer
  mct_state_e state_q, state_d;
  logic       accept;
  logic       rd_en, upd1_en, upd2_en;

  // Latched request
  logic          op_q;
  logic [KW-1:0] key_q;
  logic [CW-1:0] cnt_q;

  // Table memory and valid flags
  logic [KW-1:0]       key_mem_q [CAPACITY];
  logic [CW-1:0]       cnt_mem_q [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  logic [AW-1:0]       addr_q;
  logic [KW-1:0]       key_rd_q;
  logic [CW-1:0]       cnt_rd_q;
  logic                cmp_vld_q;
  logic [AW-1:0]       cmp_idx_q;

  // Scan trackers
  logic          hit_found_q, free_found_q, oth_any_q;
  logic [AW-1:0] hit_idx_q, free_idx_q;
  logic [CW-1:0] hit_cnt_q;
  logic [KW-1:0] lo_q, hi_q;

  // Update stage
  mct_act_e      act_q, act_d;
  logic [CW-1:0] new_cnt_q, new_cnt_d;
  logic [CW-1:0] amt_q, amt_d;
  logic [AW-1:0] tgt_idx_q;

  // Summary state
  logic [DW-1:0] distinct_q, distinct_d;
  logic [CW-1:0] total_q, total_d;

  // Result
  mct_res_t res_q, res_d;
  logic     res_vld_q;

  // Width adaption of the request fields
  logic [63:0] key_ext, cnt_ext;
  assign key_ext = 64'(req_i.key);
  assign cnt_ext = 64'(req_i.count);

  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (addr_q == AW'(CAPACITY - 1)) state_d = ST_TAIL;
      end
      ST_TAIL: state_d = ST_UPD1;
      ST_UPD1: state_d = ST_UPD2;
      ST_UPD2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    upd1_en = 1'b0;
    upd2_en = 1'b0;
    case (state_q)
      ST_IDLE: busy    = 1'b0;
      ST_SCAN: rd_en   = 1'b1;
      ST_TAIL: ;
      ST_UPD1: upd1_en = 1'b1;
      ST_UPD2: upd2_en = 1'b1;
      default: busy    = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the request on accept; the scan address starts at entry zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= key_ext[KW-1:0];
      cnt_q <= cnt_ext[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      if (accept) begin
        addr_q <= '0;
      end else if (rd_en) begin
        addr_q <= addr_q + AW'(1);
      end
      // Read data lands in the cycle after its address: track it alongside
      cmp_vld_q <= rd_en;
      cmp_idx_q <= addr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Table memory: one read port for the scan, one write port for the update
  // --------------------------------------------------------------------------
  logic wr_en;
  assign wr_en = upd2_en &&
                 (act_q == ACT_ADD_HIT || act_q == ACT_NEW || act_q == ACT_SUB_HIT);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem_q[addr_q];
      cnt_rd_q <= cnt_mem_q[addr_q];
    end
    if (wr_en) begin
      key_mem_q[tgt_idx_q] <= key_q;
      cnt_mem_q[tgt_idx_q] <= new_cnt_q;
    end
  end

  // --------------------------------------------------------------------------
  // Scan compare: match, first free entry, extremes of the other keys
  // --------------------------------------------------------------------------
  logic cmp_valid, cmp_match;
  assign cmp_valid = valid_q[cmp_idx_q];
  assign cmp_match = (key_rd_q == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      oth_any_q    <= 1'b0;
    end else if (accept) begin
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      oth_any_q    <= 1'b0;
    end else if (cmp_vld_q) begin
      if (cmp_valid && cmp_match && !hit_found_q) hit_found_q <= 1'b1;
      if (!cmp_valid && !free_found_q) free_found_q <= 1'b1;
      if (cmp_valid && !cmp_match) oth_any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) begin
      if (cmp_valid && cmp_match && !hit_found_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_cnt_q <= cnt_rd_q;
      end
      if (!cmp_valid && !free_found_q) free_idx_q <= cmp_idx_q;
      if (cmp_valid && !cmp_match) begin
        if (!oth_any_q || key_rd_q < lo_q) lo_q <= key_rd_q;
        if (!oth_any_q || key_rd_q > hi_q) hi_q <= key_rd_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // First update cycle: choose the action and the entry's new count
  // --------------------------------------------------------------------------
  logic [CW:0] cnt_sum, cnt_diff;
  logic        cnt_nz;
  assign cnt_sum  = {1'b0, hit_cnt_q} + {1'b0, cnt_q};
  assign cnt_diff = {1'b0, hit_cnt_q} - {1'b0, cnt_q};
  assign cnt_nz   = (cnt_q != '0);

  always_comb begin
    act_d     = ACT_QUERY;
    new_cnt_d = hit_cnt_q;
    amt_d     = cnt_q;
    if (cnt_nz) begin
      if (op_q == OpInsert) begin
        if (hit_found_q) begin
          act_d     = ACT_ADD_HIT;
          new_cnt_d = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];
        end else if (free_found_q) begin
          act_d     = ACT_NEW;
          new_cnt_d = cnt_q;
        end else begin
          act_d = ACT_FULL;
        end
      end else if (hit_found_q) begin
        // Over-removal floors the count and removes only what was there
        act_d     = ACT_SUB_HIT;
        new_cnt_d = cnt_diff[CW] ? '0 : cnt_diff[CW-1:0];
        amt_d     = cnt_diff[CW] ? hit_cnt_q : cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd1_en) begin
      act_q     <= act_d;
      new_cnt_q <= new_cnt_d;
      amt_q     <= amt_d;
      tgt_idx_q <= hit_found_q ? hit_idx_q : free_idx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Second update cycle: total, valid flags, distinct count and result
  // --------------------------------------------------------------------------
  logic [CW:0] tot_sum, tot_diff;
  assign tot_sum  = {1'b0, total_q} + {1'b0, cnt_q};
  assign tot_diff = {1'b0, total_q} - {1'b0, amt_q};

  logic free_entry;
  assign free_entry = (act_q == ACT_SUB_HIT) && (new_cnt_q == '0);

  always_comb begin
    total_d    = total_q;
    distinct_d = distinct_q;
    case (act_q)
      ACT_ADD_HIT: total_d = tot_sum[CW] ? '1 : tot_sum[CW-1:0];
      ACT_NEW: begin
        total_d    = tot_sum[CW] ? '1 : tot_sum[CW-1:0];
        distinct_d = distinct_q + DW'(1);
      end
      ACT_SUB_HIT: begin
        total_d = tot_diff[CW] ? '0 : tot_diff[CW-1:0];
        if (free_entry) distinct_d = distinct_q - DW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      distinct_q <= '0;
      total_q    <= '0;
    end else if (upd2_en) begin
      if (act_q == ACT_NEW) valid_q[tgt_idx_q] <= 1'b1;
      if (free_entry) valid_q[tgt_idx_q] <= 1'b0;
      distinct_q <= distinct_d;
      total_q    <= total_d;
    end
  end

  // Fold the key itself back into the extremes when it is still held
  logic          present;
  logic [KW-1:0] lo_fin, hi_fin;
  logic [CW-1:0] kc_fin;
  logic [63:0]   kc_ext, tot_ext, lo_ext, hi_ext, dist_ext;

  always_comb begin
    present = (act_q == ACT_NEW) || (hit_found_q && new_cnt_q != '0);
    kc_fin  = present ? new_cnt_q : '0;
    if (present) begin
      lo_fin = (oth_any_q && lo_q < key_q) ? lo_q : key_q;
      hi_fin = (oth_any_q && hi_q > key_q) ? hi_q : key_q;
    end else begin
      lo_fin = oth_any_q ? lo_q : '0;
      hi_fin = oth_any_q ? hi_q : '0;
    end
    kc_ext   = 64'(kc_fin);
    tot_ext  = 64'(total_d);
    lo_ext   = 64'(lo_fin);
    hi_ext   = 64'(hi_fin);
    dist_ext = 64'(distinct_d);

    res_d.key_count     = kc_ext[31:0];
    res_d.present       = present;
    res_d.distinct_keys = dist_ext[4:0];
    res_d.total_count   = tot_ext[31:0];
    res_d.least_key     = lo_ext[15:0];
    res_d.greatest_key  = hi_ext[15:0];
    res_d.empty_res     = !(present || oth_any_q);
    res_d.full_error    = (act_q == ACT_FULL);
  end

  always_ff @(posedge clk_i) begin
    if (upd2_en) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= upd2_en;
    end
  end

  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

endmodule

// File: src/mct_checker.sv
// ----------------------------------------------------------------------------
// Multiset count table checker
// Port-level properties of the multiset count table unit, bound to the top.
// ----------------------------------------------------------------------------
module mct_checker
  import mct_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input mct_res_t res_o
);

  // An accepted transaction keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("unit not busy after accepting a transaction");

  // A result arrives only once the unit has finished
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // One strobe per transaction, never two in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // An empty bag reports zero extremes and an absent key
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.empty_res |->
      res_o.least_key == 16'd0 && res_o.greatest_key == 16'd0 && !res_o.present)
    else $error("empty result with non-zero extremes or present key");

  // A dropped insert leaves the key absent
  a_full_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.full_error |-> !res_o.present && res_o.key_count == 32'd0)
    else $error("full error reported with the key present");

endmodule

bind multiset_count_table_unit mct_checker u_mct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);

// File: dv/tb_multiset_count_table_unit.sv
// ----------------------------------------------------------------------------
// Multiset count table unit testbench
// Drives insert, remove and query transactions into the unit and checks
// every result against a bag tracker that follows the table in step: key
// counts, distinct keys, saturating total and least/greatest key. A short
// directed run covers the corner cases, then a random run over a small key
// pool fills, overflows and drains the table.
// ----------------------------------------------------------------------------
module tb_multiset_count_table_unit
  import mct_pkg::*;
;

  localparam int unsigned RandomItems = 1125;
  localparam int unsigned PoolSize    = 20;

  // Tracks the bag contents and the results still owed by the unit
  class multiset_tracker;
    logic [15:0] held_key[CapacityDef];
    logic [31:0] held_count[CapacityDef];
    bit          held_used[CapacityDef];
    int unsigned distinct_held;
    logic [31:0] count_sum = '0;
    mct_res_t    due_results[$];
    int unsigned mismatch_count;

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[32] ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    // Update the bag for an accepted transaction and queue its result
    function void apply_request(mct_req_t req);
      int          hit;
      int          free_slot;
      logic [31:0] amt;
      mct_res_t    res;
      bit          seen;
      hit       = -1;
      free_slot = -1;
      res       = '0;
      seen      = 1'b0;
      for (int i = 0; i < CapacityDef; i++) begin
        if (held_used[i]) begin
          if (hit < 0 && held_key[i] == req.key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (req.count != 16'd0) begin
        if (req.op == OpInsert) begin
          if (hit >= 0) begin
            held_count[hit] = sat_add(held_count[hit], {16'd0, req.count});
            count_sum       = sat_add(count_sum, {16'd0, req.count});
          end else if (free_slot >= 0) begin
            held_used[free_slot]  = 1'b1;
            held_key[free_slot]   = req.key;
            held_count[free_slot] = {16'd0, req.count};
            distinct_held++;
            count_sum = sat_add(count_sum, {16'd0, req.count});
          end else begin
            res.full_error = 1'b1;
          end
        end else if (hit >= 0) begin
          // clip an over-removal to what the entry actually holds
          amt = ({16'd0, req.count} > held_count[hit]) ? held_count[hit] : {16'd0, req.count};
          held_count[hit] -= amt;
          count_sum = (count_sum > amt) ? count_sum - amt : 32'd0;
          if (held_count[hit] == 32'd0) begin
            held_used[hit] = 1'b0;
            distinct_held--;
          end
        end
      end
      for (int i = 0; i < CapacityDef; i++) begin
        if (!held_used[i]) continue;
        if (held_key[i] == req.key) res.key_count = held_count[i];
        if (!seen) begin
          res.least_key    = held_key[i];
          res.greatest_key = held_key[i];
          seen             = 1'b1;
        end else begin
          if (held_key[i] < res.least_key) res.least_key = held_key[i];
          if (held_key[i] > res.greatest_key) res.greatest_key = held_key[i];
        end
      end
      res.present       = (res.key_count != 32'd0);
      res.distinct_keys = distinct_held[4:0];
      res.total_count   = count_sum;
      res.empty_res     = !seen;
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    // Match a result against the oldest one owed
    function void check_result(mct_res_t got);
      mct_res_t want;
      if (due_results.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        mismatch_count++;
        return;
      end
      want = due_results.pop_front();
      compare_field("key_count", want.key_count, got.key_count);
      compare_field("present", {31'd0, want.present}, {31'd0, got.present});
      compare_field("distinct_keys", {27'd0, want.distinct_keys}, {27'd0, got.distinct_keys});
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("least_key", {16'd0, want.least_key}, {16'd0, got.least_key});
      compare_field("greatest_key", {16'd0, want.greatest_key}, {16'd0, got.greatest_key});
      compare_field("empty_res", {31'd0, want.empty_res}, {31'd0, got.empty_res});
      compare_field("full_error", {31'd0, want.full_error}, {31'd0, got.full_error});
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  mct_req_t req_i  = '0;
  logic     busy;
  logic     result_valid_o;
  mct_res_t res_o;

  multiset_tracker tracker;
  logic [15:0]     key_pool[PoolSize];

  multiset_count_table_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // All block outputs change on the edge, so the values read here are the
  // ones that held up to it: accept and result sampling is race free.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.apply_request(req_i);
      if (result_valid_o) tracker.check_result(res_o);
    end
  end

  // Hold start low for the gap, present the transaction, then wait for the
  // edge that takes it. Start is left high so a zero gap follows on directly.
  task automatic issue_op(logic op, logic [15:0] key, logic [15:0] count, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    req_i.op    <= op;
    req_i.key   <= key;
    req_i.count <= count;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    logic        op;
    logic [15:0] key;
    logic [15:0] count;
    bit          back_to_back;
    tracker = new();
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = 16'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases
    issue_op(OpInsert, 16'h0000, 16'h0000, $urandom_range(0, 7));  // query on an empty bag
    issue_op(OpRemove, 16'hFFFF, 16'h0005, $urandom_range(0, 7));  // remove of an absent key
    issue_op(OpInsert, 16'h0000, 16'hFFFF, $urandom_range(0, 7));
    issue_op(OpInsert, 16'hFFFF, 16'h0001, $urandom_range(0, 7));
    issue_op(OpInsert, 16'h0000, 16'hFFFF, $urandom_range(0, 7));  // add to a held key
    issue_op(OpRemove, 16'hFFFF, 16'hFFFF, $urandom_range(0, 7));  // over-removal frees it
    issue_op(OpRemove, 16'h0000, 16'h0000, $urandom_range(0, 7));  // query via remove
    issue_op(OpRemove, 16'h0000, 16'h0001, $urandom_range(0, 7));
    for (int k = 1; k < 16; k++) begin
      issue_op(OpInsert, 16'(k * 16'h1111), 16'(k), $urandom_range(0, 7));  // fill the table
    end
    issue_op(OpInsert, 16'h1234, 16'h0007, $urandom_range(0, 7));  // new key on a full table
    issue_op(OpInsert, 16'h1234, 16'h0000, $urandom_range(0, 7));  // query on a full table
    issue_op(OpInsert, 16'h5555, 16'h0003, $urandom_range(0, 7));  // held key, full table
    issue_op(OpRemove, 16'hFFFF, 16'hFFFF, $urandom_range(0, 7));

    // Random run: mostly pool keys so entries hit, fill and drain
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 128 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      op  = ($urandom_range(0, 99) < 55) ? OpInsert : OpRemove;
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, PoolSize - 1)]
                                         : 16'($urandom);
      case ($urandom_range(0, 9))
        0:             count = 16'h0000;
        1, 2, 3, 4, 5: count = 16'($urandom_range(1, 8));
        6, 7:          count = 16'($urandom_range(1, 16'hFFFF));
        8:             count = 16'hFFFF;
        default:       count = 16'($urandom);
      endcase
      issue_op(op, key, count, back_to_back ? 0 : $urandom_range(0, 7));
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (CapacityDef + 8) @(posedge clk_i);
    if (tracker.mismatch_count == 0) begin
      $display("tb_multiset_count_table_unit: clean");
    end else begin
      $display("tb_multiset_count_table_unit: errors");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run
  initial begin
    #30000000;
    $display("tb_multiset_count_table_unit: errors");
    $finish;
  end

endmodule
